@@ design/bam_pkg.sv @@
// ----------------------------------------------------------------------------
// bam_pkg
// Types, constants and command structs shared by the matcher modules.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int unsigned LeftMax  = 16;
  localparam int unsigned RightMax = 16;
  localparam int unsigned LW = $clog2(LeftMax);
  localparam int unsigned RW = $clog2(RightMax);
  localparam int unsigned CntW = $clog2(LeftMax + 1);
  localparam int unsigned SpW = $clog2(LeftMax + 1);

  // configuration register indexes
  localparam logic [1:0] RegPerfect = 2'd0;
  localparam logic [1:0] RegLeft    = 2'd1;
  localparam logic [1:0] RegRight   = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_GREEDY,
    S_AUG_NEXT,
    S_AUG_SCAN,
    S_AUG_FLIP,
    S_EMIT,
    S_CLEAR
  } state_e;

  typedef struct packed {
    logic load_row;
    logic greedy_step;
    logic aug_start;
    logic aug_scan;
    logic aug_flip;
    logic emit_start;
    logic emit_step;
    logic clear_all;
  } cmd_t;

  typedef struct packed {
    logic greedy_done;   // last left vertex of the greedy pass handled
    logic aug_all_done;  // no more roots (or failed)
    logic aug_skip;      // current root needs no search
    logic scan_found;    // free right vertex reached
    logic scan_dead;     // stack emptied
    logic flip_done;
    logic emit_last;
  } sts_t;

endpackage

@@ design/bam_if.sv @@
// ----------------------------------------------------------------------------
// bam_row_if / bam_res_if
// Valid/ready channels for adjacency rows and match results.
// ----------------------------------------------------------------------------
interface bam_row_if;
  logic        valid;
  logic        ready;
  logic [3:0]  row_index;
  logic [15:0] neighbor_mask;
  logic        last_row;
  modport source (output valid, row_index, neighbor_mask, last_row, input ready);
  modport sink   (input valid, row_index, neighbor_mask, last_row, output ready);
endinterface

interface bam_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] right_vertex;
  logic [3:0] left_partner;
  logic       pair_valid;
  logic [4:0] match_count;
  logic       last_result;
  modport source (output valid, right_vertex, left_partner, pair_valid, match_count,
                  last_result, input ready);
  modport sink   (input valid, right_vertex, left_partner, pair_valid, match_count,
                  last_result, output ready);
endinterface

@@ design/bam_ctrl.sv @@
// ----------------------------------------------------------------------------
// bam_ctrl
// Sequencer: load, greedy pass, stack search per root, emit, clear.
// ----------------------------------------------------------------------------
module bam_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic          in_last_i,
  input  logic          out_free_i,
  input  bam_pkg::sts_t sts_i,
  output logic          in_ready_o,
  output bam_pkg::cmd_t cmd_o
);
  import bam_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_LOAD;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load_row = in_fire_i;
        if (in_fire_i && in_last_i) state_d = S_GREEDY;
      end
      S_GREEDY: begin
        cmd_o.greedy_step = 1'b1;
        if (sts_i.greedy_done) state_d = S_AUG_NEXT;
      end
      S_AUG_NEXT: begin
        if (sts_i.aug_all_done) begin
          cmd_o.emit_start = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.aug_start = 1'b1;
          if (!sts_i.aug_skip) state_d = S_AUG_SCAN;
        end
      end
      S_AUG_SCAN: begin
        cmd_o.aug_scan = 1'b1;
        if (sts_i.scan_found) state_d = S_AUG_FLIP;
        else if (sts_i.scan_dead) state_d = S_AUG_NEXT;
      end
      S_AUG_FLIP: begin
        cmd_o.aug_flip = 1'b1;
        if (sts_i.flip_done) state_d = S_AUG_NEXT;
      end
      S_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_all = 1'b1;
        state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end
endmodule

@@ design/bam_dp.sv @@
// ----------------------------------------------------------------------------
// bam_dp
// Matching datapath: adjacency rows, partner table, visited marks, stack.
// ----------------------------------------------------------------------------
module bam_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bam_pkg::cmd_t              cmd_i,
  input  logic [bam_pkg::LW-1:0]     row_index_i,
  input  logic [15:0]                neighbor_mask_i,
  input  logic                       perfect_i,
  input  logic [4:0]                 left_count_i,
  input  logic [4:0]                 right_count_i,
  output bam_pkg::sts_t              sts_o,
  output logic [3:0]                 e_vertex_o,
  output logic [3:0]                 e_partner_o,
  output logic                       e_valid_o,
  output logic [4:0]                 e_count_o,
  output logic                       e_last_o
);
  import bam_pkg::*;

  logic [RightMax-1:0] adj_q [LeftMax];
  logic [LW-1:0]       partner_q [RightMax];
  logic [RightMax-1:0] rmatch_q;
  logic [LeftMax-1:0]  visited_q, greedy_q;
  logic [LW-1:0]       stk_v_q [LeftMax];
  logic [RW:0]         stk_n_q [LeftMax];
  logic [RW-1:0]       stk_e_q [LeftMax];
  logic [SpW-1:0]      sp_q;
  logic [CntW-1:0]     count_q;
  logic                failed_q;
  logic [LW:0]         vcnt_q;   // greedy / root index
  logic [SpW-1:0]      flip_q;
  logic [RW:0]         ej_q;

  logic [LW:0] lc;
  logic [RW:0] rc;
  always_comb begin
    lc = (left_count_i == 5'd0) ? (LW+1)'(1) :
         (left_count_i > 5'(LeftMax)) ? (LW+1)'(LeftMax) : (LW+1)'(left_count_i);
    rc = (right_count_i == 5'd0) ? (RW+1)'(1) :
         (right_count_i > 5'(RightMax)) ? (RW+1)'(RightMax) : (RW+1)'(right_count_i);
  end

  logic [RightMax-1:0] rc_mask;
  always_comb begin
    for (int j = 0; j < RightMax; j++) rc_mask[j] = (j < int'(rc));
  end

  // greedy: lowest free neighbor of vcnt
  logic [RightMax-1:0] g_cand;
  logic                g_hit;
  logic [RW-1:0]       g_j;
  always_comb begin
    g_cand = adj_q[vcnt_q[LW-1:0]] & rc_mask & ~rmatch_q;
    g_hit = |g_cand;
    g_j = '0;
    for (int j = RightMax-1; j >= 0; j--) if (g_cand[j]) g_j = RW'(j);
  end

  // scan: next neighbor of top >= stk_n
  logic [SpW-1:0]      top;
  logic [LW-1:0]       t_v;
  logic [RightMax-1:0] s_cand;
  logic                s_hit;
  logic [RW-1:0]       s_j;
  logic [LW-1:0]       s_u;
  always_comb begin
    top = sp_q - SpW'(1);
    t_v = stk_v_q[top[LW-1:0]];
    for (int j = 0; j < RightMax; j++)
      s_cand[j] = adj_q[t_v][j] && rc_mask[j] && ((RW+1)'(j) >= stk_n_q[top[LW-1:0]]);
    s_hit = |s_cand;
    s_j = '0;
    for (int j = RightMax-1; j >= 0; j--) if (s_cand[j]) s_j = RW'(j);
    s_u = partner_q[s_j];
  end

  logic [LW-1:0] root;
  assign root = vcnt_q[LW-1:0];

  always_comb begin
    sts_o.greedy_done  = (vcnt_q + (LW+1)'(1) >= lc);
    sts_o.aug_all_done = (vcnt_q >= lc) || failed_q;
    sts_o.aug_skip     = greedy_q[root] || visited_q[root];
    sts_o.scan_found   = s_hit && !rmatch_q[s_j];
    sts_o.scan_dead    = !s_hit && (sp_q == SpW'(1));
    sts_o.flip_done    = (flip_q == SpW'(1));
    sts_o.emit_last    = (ej_q + (RW+1)'(1) == rc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LeftMax; i++) adj_q[i] <= '0;
      for (int i = 0; i < RightMax; i++) partner_q[i] <= '0;
      rmatch_q <= '0; visited_q <= '0; greedy_q <= '0;
      sp_q <= '0; count_q <= '0; failed_q <= 1'b0;
      vcnt_q <= '0; flip_q <= '0; ej_q <= '0;
    end else begin
      if (cmd_i.load_row) adj_q[row_index_i] <= neighbor_mask_i;
      if (cmd_i.greedy_step) begin
        if (g_hit) begin
          rmatch_q[g_j] <= 1'b1;
          partner_q[g_j] <= root;
          greedy_q[root] <= 1'b1;
          count_q <= count_q + CntW'(1);
        end
        vcnt_q <= sts_o.greedy_done ? '0 : vcnt_q + (LW+1)'(1);
      end
      if (cmd_i.aug_start) begin
        if (sts_o.aug_skip) begin
          // visited root fails in perfect mode; greedy-matched root just skipped
          if (!greedy_q[root] && perfect_i) failed_q <= 1'b1;
          vcnt_q <= vcnt_q + (LW+1)'(1);
        end else begin
          visited_q[root] <= 1'b1;
          stk_v_q[0] <= root;
          stk_n_q[0] <= '0;
          sp_q <= SpW'(1);
        end
      end
      if (cmd_i.aug_scan) begin
        if (!s_hit) begin
          sp_q <= top;
          if (sp_q == SpW'(1)) begin
            if (perfect_i) failed_q <= 1'b1;
            vcnt_q <= vcnt_q + (LW+1)'(1);
          end
        end else begin
          stk_n_q[top[LW-1:0]] <= (RW+1)'(s_j) + (RW+1)'(1);
          stk_e_q[top[LW-1:0]] <= s_j;
          if (!rmatch_q[s_j]) begin
            flip_q <= sp_q;
          end else if (!visited_q[s_u] && sp_q < SpW'(LeftMax)) begin
            visited_q[s_u] <= 1'b1;
            stk_v_q[sp_q[LW-1:0]] <= s_u;
            stk_n_q[sp_q[LW-1:0]] <= '0;
            sp_q <= sp_q + SpW'(1);
          end
        end
      end
      if (cmd_i.aug_flip) begin
        partner_q[stk_e_q[flip_q[LW-1:0] - LW'(1)]] <= stk_v_q[flip_q[LW-1:0] - LW'(1)];
        rmatch_q[stk_e_q[flip_q[LW-1:0] - LW'(1)]] <= 1'b1;
        flip_q <= flip_q - SpW'(1);
        if (flip_q == SpW'(1)) begin
          count_q <= count_q + CntW'(1);
          visited_q <= '0;
          vcnt_q <= vcnt_q + (LW+1)'(1);
        end
      end
      if (cmd_i.emit_start) ej_q <= '0;
      if (cmd_i.emit_step) ej_q <= ej_q + (RW+1)'(1);
      if (cmd_i.clear_all) begin
        for (int i = 0; i < LeftMax; i++) adj_q[i] <= '0;
        for (int i = 0; i < RightMax; i++) partner_q[i] <= '0;
        rmatch_q <= '0; visited_q <= '0; greedy_q <= '0;
        sp_q <= '0; count_q <= '0; failed_q <= 1'b0;
        vcnt_q <= '0; ej_q <= '0;
      end
    end
  end

  always_comb begin
    e_vertex_o  = ej_q[RW-1:0];
    e_valid_o   = !failed_q && rmatch_q[ej_q[RW-1:0]];
    e_partner_o = e_valid_o ? partner_q[ej_q[RW-1:0]] : '0;
    e_count_o   = failed_q ? 5'd0 : 5'(count_q);
    e_last_o    = sts_o.emit_last;
  end
endmodule

@@ design/bipartite_augmenting_matcher.sv @@
// ----------------------------------------------------------------------------
// bipartite_augmenting_matcher
// Maximum bipartite matching: greedy pass, then stack-based augmenting search.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  row_in    in   valid/ready      row_index, neighbor_mask, last_row
//  res_out   out  valid/ready      right_vertex, left_partner, pair_valid, ...
//  apb       in   psel/penable     zero_if_not_perfect, left_count, right_count
//
//  Rows load one per cycle. After the last row: a greedy pass over left_count
//  left vertices, then per left vertex a step to start or skip its search,
//  its stack steps and its flipped edges, then a step to leave the search,
//  right_count results at one per cycle while the output is free, then clearing state.
//  Result stalls hold the emitter; rows are refused until the run ends.
//  Reset clears the adjacency rows and the matching; registers go to default.
module bipartite_augmenting_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  bam_row_if.sink     row_in,
  bam_res_if.source   res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bam_pkg::*;

  logic       perfect_q;
  logic [4:0] lcnt_q, rcnt_q;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perfect_q <= 1'b0; lcnt_q <= 5'd16; rcnt_q <= 5'd16;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        RegPerfect: perfect_q <= pwdata[0];
        RegLeft:    lcnt_q <= pwdata[4:0];
        RegRight:   rcnt_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPerfect: prdata = {31'd0, perfect_q};
      RegLeft:    prdata = {27'd0, lcnt_q};
      RegRight:   prdata = {27'd0, rcnt_q};
      default:    prdata = '0;
    endcase
  end

  cmd_t cmd;
  sts_t sts;
  logic in_ready, out_free;
  logic [3:0] e_v, e_p;
  logic e_ok, e_last;
  logic [4:0] e_cnt;
  logic out_valid_q;
  logic [3:0] ov_q, op_q;
  logic opv_q, olast_q;
  logic [4:0] ocnt_q;

  assign row_in.ready = in_ready;
  assign out_free = !out_valid_q || res_out.ready;

  bam_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (row_in.valid && in_ready),
    .in_last_i (row_in.last_row),
    .out_free_i(out_free),
    .sts_i     (sts),
    .in_ready_o(in_ready),
    .cmd_o     (cmd)
  );

  bam_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i          (cmd),
    .row_index_i    (row_in.row_index),
    .neighbor_mask_i(row_in.neighbor_mask),
    .perfect_i      (perfect_q),
    .left_count_i   (lcnt_q),
    .right_count_i  (rcnt_q),
    .sts_o          (sts),
    .e_vertex_o     (e_v),
    .e_partner_o    (e_p),
    .e_valid_o      (e_ok),
    .e_count_o      (e_cnt),
    .e_last_o       (e_last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (out_free) out_valid_q <= cmd.emit_step;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit_step) begin
      ov_q <= e_v; op_q <= e_p; opv_q <= e_ok; ocnt_q <= e_cnt; olast_q <= e_last;
    end
  end

  assign res_out.valid        = out_valid_q;
  assign res_out.right_vertex = ov_q;
  assign res_out.left_partner = op_q;
  assign res_out.pair_valid   = opv_q;
  assign res_out.match_count  = ocnt_q;
  assign res_out.last_result  = olast_q;

  a_no_row_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.greedy_step || cmd.aug_scan || cmd.aug_flip) |-> !in_ready)
    else $error("row accepted during a run");
  a_emit_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_step |-> out_free)
    else $error("emit into a full output register");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_step && e_last) |=> cmd.clear_all)
    else $error("no clear after last result");
endmodule
